>>> sv/rsa_pkg.sv
// Package: shared constants for the RGB saturation adjust pipeline.
`timescale 1ns / 1ps

package rsa_pkg;

    localparam int WEIGHT_BITS = 16;
    localparam int GAIN_BITS   = 12;
    localparam int FRAC_BITS   = 8;
    localparam int NUM_CHAN    = 3;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_R = 16'd19595;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_G = 16'd38470;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_B = 16'd7471;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 12'd256;

    function automatic logic [WEIGHT_BITS-1:0] chan_weight(input logic [1:0] idx);
        logic [WEIGHT_BITS-1:0] w;
        case (idx)
            2'd0:    w = WEIGHT_R;
            2'd1:    w = WEIGHT_G;
            default: w = WEIGHT_B;
        endcase
        return w;
    endfunction

endpackage

>>> sv/rsa_luma.sv
// Three-stage weighted sum of squared channels (perceived brightness squared).
`timescale 1ns / 1ps

module rsa_luma
    import rsa_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           ce,
    input  logic                           in_valid,
    input  logic [NUM_CHAN*CHANNEL_BITS-1:0] in_rgb,
    output logic                           out_valid,
    output logic [NUM_CHAN*CHANNEL_BITS-1:0] out_rgb,
    output logic [2*CHANNEL_BITS-1:0]      out_sum
);

    localparam int W   = CHANNEL_BITS;
    localparam int SQW = 2 * W;
    localparam int WPW = SQW + WEIGHT_BITS;
    localparam int SMW = WPW + 2;

    logic [SQW-1:0]      sq_reg [NUM_CHAN];
    logic [WPW-1:0]      wp_reg [NUM_CHAN];
    logic [SQW-1:0]      sum_reg;
    logic [2:0]          vld_reg;
    logic [NUM_CHAN*W-1:0] rgb1_reg;
    logic [NUM_CHAN*W-1:0] rgb2_reg;
    logic [NUM_CHAN*W-1:0] rgb3_reg;
    logic [SMW-1:0]      sum_next;

    genvar c;
    generate
        for (c = 0; c < NUM_CHAN; c++) begin : g_lane
            logic [W-1:0] chan;
            assign chan = in_rgb[c*W +: W];
            always_ff @(posedge aclk) begin
                if (ce) begin
                    sq_reg[c] <= SQW'(chan * chan);
                    wp_reg[c] <= WPW'(sq_reg[c] * chan_weight(2'(c)));
                end
            end
        end
    endgenerate

    always_comb begin
        sum_next = SMW'(wp_reg[0]) + SMW'(wp_reg[1]) + SMW'(wp_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rgb1_reg <= in_rgb;
            rgb2_reg <= rgb1_reg;
            rgb3_reg <= rgb2_reg;
            sum_reg  <= sum_next[WEIGHT_BITS +: SQW];
        end
    end

    assign out_valid = vld_reg[2];
    assign out_rgb   = rgb3_reg;
    assign out_sum   = sum_reg;

endmodule

>>> sv/rsa_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side payload.
`timescale 1ns / 1ps

module rsa_sqrt
    import rsa_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           ce,
    input  logic                           in_valid,
    input  logic [2*CHANNEL_BITS-1:0]      in_x,
    input  logic [NUM_CHAN*CHANNEL_BITS-1:0] in_pay,
    output logic                           out_valid,
    output logic [CHANNEL_BITS-1:0]        out_root,
    output logic [NUM_CHAN*CHANNEL_BITS-1:0] out_pay
);

    localparam int W  = CHANNEL_BITS;
    localparam int XW = 2 * W;
    localparam int TW = W + 3;
    localparam int PW = NUM_CHAN * W;

    logic [W:0]    rem_reg  [1:W];
    logic [W-1:0]  root_reg [1:W];
    logic [XW-1:0] xs_reg   [1:W];
    logic [PW-1:0] pay_reg  [1:W];
    logic [W:1]    vld_reg;

    genvar k;
    generate
        for (k = 1; k <= W; k++) begin : g_stage
            logic [W:0]    src_rem;
            logic [W-1:0]  src_root;
            logic [XW-1:0] src_x;
            logic [PW-1:0] src_pay;
            logic          src_vld;
            logic [TW-1:0] t;
            logic [TW-1:0] trial;
            logic          ge;

            if (k == 1) begin : g_first
                assign src_rem  = '0;
                assign src_root = '0;
                assign src_x    = in_x;
                assign src_pay  = in_pay;
                assign src_vld  = in_valid;
            end else begin : g_next
                assign src_rem  = rem_reg[k-1];
                assign src_root = root_reg[k-1];
                assign src_x    = xs_reg[k-1];
                assign src_pay  = pay_reg[k-1];
                assign src_vld  = vld_reg[k-1];
            end

            assign t     = {src_rem, src_x[XW-1 -: 2]};
            assign trial = {1'b0, src_root, 2'b01};
            assign ge    = (t >= trial);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (ce) begin
                    vld_reg[k] <= src_vld;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k]  <= ge ? (W+1)'(t - trial) : (W+1)'(t);
                    root_reg[k] <= {src_root[W-2:0], ge};
                    xs_reg[k]   <= {src_x[XW-3:0], 2'b00};
                    pay_reg[k]  <= src_pay;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[W];
    assign out_root  = root_reg[W];
    assign out_pay   = pay_reg[W];

endmodule

>>> sv/rsa_adjust.sv
// Two-stage gain multiply around the brightness, then truncate and clamp.
`timescale 1ns / 1ps

module rsa_adjust
    import rsa_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           ce,
    input  logic                           in_valid,
    input  logic [CHANNEL_BITS-1:0]        in_p,
    input  logic [NUM_CHAN*CHANNEL_BITS-1:0] in_rgb,
    input  logic [GAIN_BITS-1:0]           gain,
    output logic                           out_valid,
    output logic [NUM_CHAN*CHANNEL_BITS-1:0] out_rgb
);

    localparam int W  = CHANNEL_BITS;
    localparam int MW = W + 1 + GAIN_BITS + 1;
    localparam int VW = MW + 1;
    localparam int QW = VW - FRAC_BITS;
    localparam logic [W-1:0] CHAN_MAX = '1;

    logic signed [MW-1:0] prod_reg [NUM_CHAN];
    logic [W-1:0]         p_reg;
    logic [NUM_CHAN*W-1:0] res_reg;
    logic [1:0]           vld_reg;

    genvar c;
    generate
        for (c = 0; c < NUM_CHAN; c++) begin : g_lane
            logic signed [W:0]    diff;
            logic signed [VW-1:0] v;
            logic [QW-1:0]        q;
            logic [W-1:0]         res;

            assign diff = $signed({1'b0, in_rgb[c*W +: W]}) - $signed({1'b0, in_p});

            always_ff @(posedge aclk) begin
                if (ce) begin
                    prod_reg[c] <= MW'(diff * $signed({1'b0, gain}));
                end
            end

            assign v = VW'(prod_reg[c]) + $signed(VW'({p_reg, {FRAC_BITS{1'b0}}}));
            assign q = v[VW-1:FRAC_BITS];

            always_comb begin
                if (v[VW-1]) begin
                    res = '0;
                end else if (|q[QW-1:W]) begin
                    res = CHAN_MAX;
                end else begin
                    res = q[W-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    res_reg[c*W +: W] <= res;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg <= in_p;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    assign out_valid = vld_reg[1];
    assign out_rgb   = res_reg;

endmodule

>>> sv/rgb_saturation_adjust.sv
// Top level: HSP saturation adjust pipeline with output register and skid stage.
//
//   channel  dir  handshake           payload
//   s_       in   s_tvalid/s_tready   s_tdata: red_in, green_in, blue_in
//   m_       out  m_tvalid/m_tready   m_tdata: red_out, green_out, blue_out
//   cfg_     in   cfg_valid/cfg_ready cfg_data: saturation_gain (Q4.8)
//
// One item per cycle while the output is not stalled; each item passes through
// 3 luma stages, one square-root stage per result bit, 2 gain stages, output reg.
// Reset (synchronous, aresetn low) clears all valid bits and sets the gain to 1.0.
// The pipeline advances as a whole while the skid stage is empty; a stalled
// output fills the skid with one item and then holds s_tready low.
`timescale 1ns / 1ps

module rgb_saturation_adjust
    import rsa_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [W-1:0] red_in, [2W-1:W] green_in, [3W-1:2W] blue_in, zero pad above
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [W-1:0] red_out, [2W-1:W] green_out, [3W-1:2W] blue_out, zero pad above
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [GAIN_BITS-1:0] cfg_data
);

    localparam int W  = CHANNEL_BITS;
    localparam int PW = NUM_CHAN * W;
    localparam int TD = ((3*CHANNEL_BITS+7)/8)*8;

    logic [GAIN_BITS-1:0] gain_reg;
    logic                 ce;
    logic                 luma_valid;
    logic [PW-1:0]        luma_rgb;
    logic [2*W-1:0]       luma_sum;
    logic                 sqrt_valid;
    logic [W-1:0]         sqrt_root;
    logic [PW-1:0]        sqrt_rgb;
    logic                 pipe_valid;
    logic [PW-1:0]        pipe_rgb;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [PW-1:0]        out_data_reg, out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [PW-1:0]        skid_data_reg, skid_data_next;
    logic                 out_take;
    logic                 push;

    assign ce        = !skid_valid_reg;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_valid) begin
            gain_reg <= cfg_data;
        end
    end

    rsa_luma #(.CHANNEL_BITS(W)) u_luma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_rgb    (s_tdata[PW-1:0]),
        .out_valid (luma_valid),
        .out_rgb   (luma_rgb),
        .out_sum   (luma_sum)
    );

    rsa_sqrt #(.CHANNEL_BITS(W)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (luma_valid),
        .in_x      (luma_sum),
        .in_pay    (luma_rgb),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_pay   (sqrt_rgb)
    );

    rsa_adjust #(.CHANNEL_BITS(W)) u_adjust (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sqrt_valid),
        .in_p      (sqrt_root),
        .in_rgb    (sqrt_rgb),
        .gain      (gain_reg),
        .out_valid (pipe_valid),
        .out_rgb   (pipe_rgb)
    );

    assign out_take = m_tvalid_reg && m_tready;
    assign push     = ce && pipe_valid;

    always_comb begin
        m_tvalid_next   = m_tvalid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!m_tvalid_reg || out_take) begin
                m_tvalid_next = 1'b1;
                out_data_next = pipe_rgb;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = pipe_rgb;
            end
        end else if (out_take) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_tvalid_reg   <= m_tvalid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TD'(out_data_reg);

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid holds an item while output register is empty");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid item changed or lost during output stall");

    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_tvalid_reg && !m_tready && pipe_valid))
        else $error("skid filled without a stalled output");

endmodule

>>> test/tb_rgb_saturation_adjust.sv
// Testbench: rgb_saturation_adjust checked against a local HSP saturation predictor.
`timescale 1ns / 1ps

module tb_rgb_saturation_adjust;
    import rsa_pkg::*;

    localparam int CHAN_W     = 8;
    localparam int TDATA_W    = ((3 * CHAN_W + 7) / 8) * 8;
    localparam int LATENCY    = CHAN_W + 6;
    localparam int LONG_HOLD  = 80;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 244;
    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t          expected_pixels[$];
        logic [GAIN_BITS-1:0] gain;
        int              errors;
        int              checked;

        function new();
            gain    = GAIN_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function logic [CHAN_W-1:0] adjust_chan(logic [CHAN_W-1:0] c, longint luma);
            longint v;
            longint q;
            v = luma * 256 + (longint'(c) - luma) * longint'(gain);
            if (v <= 0)
                return '0;
            q = v >>> FRAC_BITS;
            if (q > longint'(CHAN_MAX))
                return CHAN_MAX;
            return q[CHAN_W-1:0];
        endfunction

        function pixel_t saturate_pixel(pixel_t px);
            longint unsigned sum;
            longint unsigned rem;
            longint unsigned root;
            longint unsigned bitv;
            pixel_t          res;
            sum = 64'(WEIGHT_R) * 64'(px.red) * 64'(px.red)
                + 64'(WEIGHT_G) * 64'(px.green) * 64'(px.green)
                + 64'(WEIGHT_B) * 64'(px.blue) * 64'(px.blue);
            rem  = sum >> WEIGHT_BITS;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem  = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            res.red   = adjust_chan(px.red, longint'(root));
            res.green = adjust_chan(px.green, longint'(root));
            res.blue  = adjust_chan(px.blue, longint'(root));
            return res;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50)
                $display("MISMATCH: %s", what);
        endtask

        function void note_input(pixel_t px);
            expected_pixels.push_back(saturate_pixel(px));
        endfunction

        task check_result(pixel_t px);
            pixel_t exp_px;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected pixel %h", px));
                return;
            end
            exp_px = expected_pixels.pop_front();
            checked++;
            if (px.red !== exp_px.red)
                report($sformatf("red %0d, expected %0d (gain %0d)", px.red, exp_px.red, gain));
            if (px.green !== exp_px.green)
                report($sformatf("green %0d, expected %0d (gain %0d)",
                                 px.green, exp_px.green, gain));
            if (px.blue !== exp_px.blue)
                report($sformatf("blue %0d, expected %0d (gain %0d)",
                                 px.blue, exp_px.blue, gain));
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    logic [TDATA_W-1:0]   m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [GAIN_BITS-1:0] cfg_data  = '0;

    pixel_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_done      = 0;
    int gain_writes    = 0;

    rgb_saturation_adjust #(
        .CHANNEL_BITS(CHAN_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // handshakes are stable between edges; sample mid-cycle
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_input(pixel_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_result(pixel_t'(m_tdata));
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_req != hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                hold_done = hold_done + 1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                    input logic [CHAN_W-1:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(px);
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task drain_pixels();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task write_gain(input logic [GAIN_BITS-1:0] g);
        drain_pixels();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.gain = g;
        gain_writes++;
    endtask

    function logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CHAN_MAX;
            default: return CHAN_W'($urandom_range(CHAN_MAX));
        endcase
    endfunction

    initial begin
        logic [GAIN_BITS-1:0] phase_gain;
        logic [CHAN_W-1:0]    r;
        logic [CHAN_W-1:0]    g;
        logic [CHAN_W-1:0]    b;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset gain of 1.0: pass-through
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        send_pixel(1, 2, 3);
        send_pixel(128, 64, 32);
        send_pixel(255, 255, 0);
        send_pixel(0, 255, 255);
        send_pixel(255, 0, 255);

        // maximum gain: clamps on both ends
        write_gain(12'hfff);
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        send_pixel(200, 100, 50);
        send_pixel(255, 255, 255);
        send_pixel(1, 0, 0);
        send_pixel(10, 200, 30);

        // zero gain: grey
        write_gain(12'd0);
        send_pixel(255, 0, 0);
        send_pixel(17, 99, 201);
        send_pixel(0, 0, 0);
        send_pixel(128, 128, 128);
        send_pixel(255, 255, 255);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       phase_gain = GAIN_RESET;
                1:       phase_gain = 12'hfff;
                2:       phase_gain = 12'd0;
                3:       phase_gain = 12'd1;
                4:       phase_gain = 12'd512;
                5:       phase_gain = GAIN_BITS'($urandom_range(4095));
                6:       phase_gain = 12'd2048;
                default: phase_gain = GAIN_BITS'($urandom_range(384, 1));
            endcase
            write_gain(phase_gain);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 50)
                    hold_req = hold_req + 1;
                if (ph == 5 && n == 100)
                    drain_pixels();
                r = rand_chan();
                if ($urandom_range(15) == 0) begin
                    g = r;
                    b = r;
                end else begin
                    g = rand_chan();
                    b = rand_chan();
                end
                send_pixel(r, g, b);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected pixels never came out", sb.pending()));

        $display("Checked %0d pixels over %0d gain writes: extremes, grey, clamps,",
                 sb.checked, gain_writes);
        $display("random pixels under sender gaps, receiver stalls and a long hold-off.");
        if (sb.errors == 0)
            $display("tb_rgb_saturation_adjust: clean");
        else
            $display("tb_rgb_saturation_adjust: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TIMEOUT with %0d pixels outstanding", sb.pending());
        $display("tb_rgb_saturation_adjust: errors");
        $finish;
    end

endmodule
